FILE: hdl/swsfr_pkg.sv
// Shared types, constants and helpers of the single-wire sensor frame reader.
package swsfr_pkg;

    localparam int FRAME_BITS  = 40;
    localparam int NBYTES      = (FRAME_BITS - 8) / 8;
    localparam int BIT_INDEX_W = $clog2(FRAME_BITS);
    localparam int CFG_DATA_W  = 22;
    localparam int CFG_INDEX_W = 3;

    localparam logic [15:0] START_LOW_RESET    = 16'd20000;
    localparam logic [7:0]  RELEASE_RESET      = 8'd30;
    localparam logic [15:0] TIMEOUT_RESET      = 16'd20000;
    localparam logic [7:0]  THRESHOLD_RESET    = 8'd50;
    localparam logic [21:0] MIN_INTERVAL_RESET = 22'd2000000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_LOW    = 3'd0,
        CFG_RELEASE      = 3'd1,
        CFG_TIMEOUT      = 3'd2,
        CFG_THRESHOLD    = 3'd3,
        CFG_MIN_INTERVAL = 3'd4
    } swsfr_cfg_index_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_TIMEOUT  = 2'd1,
        STAT_CHECKSUM = 2'd2
    } swsfr_status_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_LOW      = 4'd1,
        PH_HIGH     = 4'd2,
        PH_RESP_A   = 4'd3,
        PH_RESP_B   = 4'd4,
        PH_RESP_C   = 4'd5,
        PH_BIT_LOW  = 4'd6,
        PH_BIT_HIGH = 4'd7
    } swsfr_phase_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [15:0] response_timeout;
        logic [7:0]  one_threshold;
        logic [21:0] min_interval;
    } swsfr_cfg_t;

    typedef struct packed {
        logic start_req;
        logic line_level;
    } swsfr_in_t;

    typedef struct packed {
        logic        drive_enable;
        logic        drive_level;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [7:0]  byte_zero;
        logic [7:0]  byte_one;
        logic [7:0]  byte_two;
        logic [7:0]  byte_three;
    } swsfr_out_t;

    // Data byte k of a frame, first received bits first; zero past the data bytes.
    function automatic logic [7:0] frame_byte(input logic [FRAME_BITS-1:0] frame,
                                              input int k);
        logic [FRAME_BITS-1:0] sh;
        sh = '0;
        if (k < NBYTES)
        begin
            sh = frame >> (FRAME_BITS - 8 * (k + 1));
        end
        return sh[7:0];
    endfunction

endpackage

FILE: hdl/swsfr_cfg.sv
// Configuration register file of the single-wire sensor frame reader.
module swsfr_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [swsfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swsfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output swsfr_pkg::swsfr_cfg_t          cfg
);
    import swsfr_pkg::*;

    swsfr_cfg_t cfg_reg;
    swsfr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_START_LOW:    cfg_next.start_low_ticks  = cfg_data[15:0];
                CFG_RELEASE:      cfg_next.release_ticks    = cfg_data[7:0];
                CFG_TIMEOUT:      cfg_next.response_timeout = cfg_data[15:0];
                CFG_THRESHOLD:    cfg_next.one_threshold    = cfg_data[7:0];
                CFG_MIN_INTERVAL: cfg_next.min_interval     = cfg_data[21:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks  <= START_LOW_RESET;
            cfg_reg.release_ticks    <= RELEASE_RESET;
            cfg_reg.response_timeout <= TIMEOUT_RESET;
            cfg_reg.one_threshold    <= THRESHOLD_RESET;
            cfg_reg.min_interval     <= MIN_INTERVAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/swsfr_core.sv
// Protocol sequencer: line timing, bit capture, checksum and result per item.
module swsfr_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  swsfr_pkg::swsfr_cfg_t cfg,
    input  logic                  accept,
    input  swsfr_pkg::swsfr_in_t  item,
    output swsfr_pkg::swsfr_out_t result
);
    import swsfr_pkg::*;

    swsfr_phase_t           phase_reg, phase_next;
    logic [15:0]            drive_reg, drive_next;
    logic [15:0]            deadline_reg, deadline_next;
    logic [15:0]            high_time_reg, high_time_next;
    logic [BIT_INDEX_W-1:0] bit_index_reg, bit_index_next;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;
    logic [21:0]            since_reg, since_next;

    logic                   too_soon, start_ok, low_tick, low_end, high_end;
    logic [15:0]            drive_inc, low_limit, high_time_inc;
    logic [16:0]            elapsed;
    logic                   in_resp, advanced, timed_out, last_bit, frame_end;
    logic                   bit_val, checksum_ok, success;
    logic [FRAME_BITS-1:0]  frame_shift;
    logic [7:0]             byte_sum;

    assign too_soon  = since_reg < cfg.min_interval;
    assign start_ok  = (phase_reg == PH_IDLE) && item.start_req && !too_soon;
    assign low_tick  = start_ok || (phase_reg == PH_LOW);
    assign drive_inc = (start_ok ? 16'd0 : drive_reg) + 16'd1;
    assign low_limit = (cfg.start_low_ticks == 16'd0) ? 16'd1 : cfg.start_low_ticks;
    assign low_end   = low_tick && (drive_inc >= low_limit);
    assign high_end  = (phase_reg == PH_HIGH) && (drive_inc >= {8'd0, cfg.release_ticks});

    assign in_resp = (phase_reg == PH_RESP_A) || (phase_reg == PH_RESP_B) ||
                     (phase_reg == PH_RESP_C) || (phase_reg == PH_BIT_LOW) ||
                     (phase_reg == PH_BIT_HIGH);
    assign elapsed = {1'b0, deadline_reg} + 17'd1;

    assign high_time_inc = (high_time_reg == 16'hFFFF) ? high_time_reg
                                                       : high_time_reg + 16'd1;
    assign bit_val     = high_time_inc > {8'd0, cfg.one_threshold};
    assign frame_shift = {frame_reg[FRAME_BITS-2:0], bit_val};
    assign last_bit    = bit_index_reg >= BIT_INDEX_W'(FRAME_BITS - 1);

    always_comb
    begin
        case (phase_reg)
            PH_RESP_A:   advanced = !item.line_level;
            PH_RESP_B:   advanced = item.line_level;
            PH_RESP_C:   advanced = !item.line_level;
            PH_BIT_LOW:  advanced = item.line_level;
            PH_BIT_HIGH: advanced = !item.line_level;
            default:     advanced = 1'b0;
        endcase
    end

    assign timed_out = in_resp && !advanced && (elapsed > {1'b0, cfg.response_timeout});
    assign frame_end = (phase_reg == PH_BIT_HIGH) && !item.line_level && last_bit;

    always_comb
    begin
        byte_sum = 8'd0;
        for (int k = 0; k < NBYTES; k++)
        begin
            byte_sum = byte_sum + frame_byte(frame_shift, k);
        end
    end

    assign checksum_ok = byte_sum == frame_shift[7:0];
    assign success     = frame_end && checksum_ok;

    // Next state
    always_comb
    begin
        phase_next     = phase_reg;
        drive_next     = drive_reg;
        deadline_next  = deadline_reg;
        high_time_next = high_time_reg;
        bit_index_next = bit_index_reg;
        frame_next     = frame_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                if (start_ok)
                begin
                    frame_next     = '0;
                    bit_index_next = '0;
                    high_time_next = '0;
                    phase_next     = PH_LOW;
                end
            end
            PH_LOW:
            begin
                phase_next = PH_LOW;
            end
            PH_HIGH:
            begin
                drive_next = drive_inc;
                if (high_end)
                begin
                    phase_next    = PH_RESP_A;
                    deadline_next = '0;
                end
            end
            PH_RESP_A, PH_RESP_B, PH_RESP_C, PH_BIT_LOW, PH_BIT_HIGH:
            begin
                deadline_next = elapsed[16] ? 16'hFFFF : elapsed[15:0];
                case (phase_reg)
                    PH_RESP_A:
                    begin
                        if (advanced) phase_next = PH_RESP_B;
                    end
                    PH_RESP_B:
                    begin
                        if (advanced) phase_next = PH_RESP_C;
                    end
                    PH_RESP_C:
                    begin
                        if (advanced)
                        begin
                            phase_next     = PH_BIT_LOW;
                            bit_index_next = '0;
                        end
                    end
                    PH_BIT_LOW:
                    begin
                        if (advanced)
                        begin
                            phase_next     = PH_BIT_HIGH;
                            high_time_next = '0;
                        end
                    end
                    default:
                    begin
                        high_time_next = high_time_inc;
                        if (advanced)
                        begin
                            frame_next = frame_shift;
                            if (last_bit)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                bit_index_next = bit_index_reg + BIT_INDEX_W'(1);
                                phase_next     = PH_BIT_LOW;
                            end
                        end
                    end
                endcase
                if (timed_out)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Start pulse count, shared by the start tick and the low phase
        if (low_tick)
        begin
            drive_next = drive_inc;
            if (low_end)
            begin
                drive_next = '0;
                if (cfg.release_ticks == 8'd0)
                begin
                    phase_next    = PH_RESP_A;
                    deadline_next = '0;
                end
                else
                begin
                    phase_next = PH_HIGH;
                end
            end
        end
    end

    always_comb
    begin
        if (success)
            since_next = '0;
        else if (since_reg != 22'h3FFFFF)
            since_next = since_reg + 22'd1;
        else
            since_next = since_reg;
    end

    // Outputs
    always_comb
    begin
        result              = '0;
        result.drive_enable = low_tick || (phase_reg == PH_HIGH);
        result.drive_level  = (phase_reg == PH_HIGH);
        result.busy_res     = (phase_next != PH_IDLE);
        if ((phase_reg == PH_IDLE) && item.start_req && too_soon)
        begin
            result.done_res = 1'b1;
            result.status   = STAT_TIMEOUT;
        end
        else if (timed_out)
        begin
            result.done_res = 1'b1;
            result.status   = STAT_TIMEOUT;
        end
        else if (frame_end)
        begin
            result.done_res   = 1'b1;
            result.status     = checksum_ok ? STAT_OK : STAT_CHECKSUM;
            result.byte_zero  = frame_byte(frame_shift, 0);
            result.byte_one   = frame_byte(frame_shift, 1);
            result.byte_two   = frame_byte(frame_shift, 2);
            result.byte_three = frame_byte(frame_shift, 3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            drive_reg     <= '0;
            deadline_reg  <= '0;
            high_time_reg <= '0;
            bit_index_reg <= '0;
            frame_reg     <= '0;
            since_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            drive_reg     <= drive_next;
            deadline_reg  <= deadline_next;
            high_time_reg <= high_time_next;
            bit_index_reg <= bit_index_next;
            frame_reg     <= frame_next;
            since_reg     <= since_next;
        end
    end

endmodule

FILE: hdl/swsfr_out_reg.sv
// Result register stage with valid/ready towards the consumer.
module swsfr_out_reg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  swsfr_pkg::swsfr_out_t result,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output swsfr_pkg::swsfr_out_t out_item
);
    import swsfr_pkg::*;

    logic       valid_reg, valid_next;
    swsfr_out_t data_reg;

    assign room = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign out_valid = valid_reg;
    assign out_item  = data_reg;

endmodule

FILE: hdl/single_wire_sensor_frame_reader.sv
// Top level of the single-wire sensor frame reader.
//
// Each input item is one microsecond tick carrying the sampled data line level and a start
// request; each item yields exactly one result item, registered, in the cycle after it is
// accepted. On a start request while idle the reader refuses at once with timeout status if
// fewer than min_interval ticks have passed since reset or the last good read; otherwise it drives the
// line low for start_low_ticks ticks (zero acts as one), high for release_ticks ticks, then
// releases it and follows the sensor's three response levels and the data bits, MSB first.
// A bit reads as one when its high time exceeds one_threshold. Everything after the release
// must finish within response_timeout ticks, and the last byte must equal the sum modulo 256
// of the data bytes before it. The four data bytes appear only on the done item of a
// complete frame. Throughput is one item per cycle: all per-tick work is a single pass
// through the sequencer between its state registers and the result register, and the input
// side stalls only while the result register holds an item the consumer has not taken.
// Configuration registers are written by index and take effect on the next item; write them
// only while no read is in progress.
module single_wire_sensor_frame_reader (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  swsfr_pkg::swsfr_in_t              in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output swsfr_pkg::swsfr_out_t             out_item,
    input  logic                              cfg_write,
    input  logic [swsfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swsfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import swsfr_pkg::*;

    swsfr_cfg_t cfg;
    swsfr_out_t result;
    logic       accept;
    logic       room;

    // Take a tick whenever the result register is free or being emptied this cycle
    assign in_ready = room;
    assign accept   = in_valid && room;

    swsfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer state advances only on accepted ticks
    swsfr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .item   (in_item),
        .result (result)
    );

    swsfr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (result),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`ifndef SYNTHESIS
    // A finished read never reports itself still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.done_res |-> !out_item.busy_res)
        else $error("done item reports busy");

    // Status and the first data byte stay clear on items that do not end a read
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.done_res |->
            (out_item.status == STAT_OK) && (out_item.byte_zero == 8'd0))
        else $error("status or data set without done");

    // The line is driven high only while the block owns it
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.drive_level |-> out_item.drive_enable)
        else $error("drive level set without drive enable");

    // The input side stalls only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with free result register");
`endif

endmodule
